[design/twsm_pkg.sv]
// package for the two-wire sensor serial master
// holds the phase type, command codes, register indexes and the result record
// no dependencies
package twsm_pkg;

    // command codes carried in the request kind
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_WRITE  = 2'd2;
    localparam logic [1:0] OP_RESYNC = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_HALF_BIT    = 2'd0;
    localparam logic [1:0] CFG_HOLD        = 2'd1;
    localparam logic [1:0] CFG_RESYNC_LOW  = 2'd2;
    localparam logic [1:0] CFG_RESYNC_WAIT = 2'd3;

    // reset values of the configuration registers
    localparam logic [7:0]  HALF_BIT_RESET    = 8'd5;
    localparam logic [7:0]  HOLD_RESET        = 8'd3;
    localparam logic [7:0]  RESYNC_LOW_RESET  = 8'd1;
    localparam logic [15:0] RESYNC_WAIT_RESET = 16'd2000;

    // write frames carry the address with the top bit set
    localparam logic [7:0] WRITE_FLAG = 8'h80;
    localparam logic [3:0] READ_LAST_BIT  = 4'd7;
    localparam logic [3:0] WRITE_LAST_BIT = 4'd15;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_SEND   = 3'd1,
        PH_HOLD   = 3'd2,
        PH_RECV   = 3'd3,
        PH_RSLOW  = 3'd4,
        PH_RSWAIT = 3'd5
    } phase_t;

    // one result per tick
    typedef struct packed {
        logic       busy;
        logic [7:0] read_value;
        logic       drive_low;
        logic       sclk;
        logic       done;
    } result_t;

endpackage

[design/two_wire_sensor_serial_master.sv]
// two-wire sensor serial master: clock plus one open-drain data line
// one request per base tick, one result per request; uses twsm_pkg
//
// channel   dir  handshake            payload
// s_        in   s_tvalid/s_tready    s_tdata: reg_addr, write_value, sdio_in; s_tuser: op
// m_        out  m_tvalid/m_tready    m_tdata: sclk, drive, read_value, busy; m_tlast: done
// cfg_      in   cfg_we               cfg_index, cfg_wdata
//
// every request is handled combinationally: the tick logic sits between the phase
// registers and the output register, so one request is taken each clock while s_tready is high
// a two-entry output stage (output register plus skid) keeps s_tready
// registered; a stalled result costs no request until both entries are full
// aresetn is synchronous and active low; it clears the tick state, the output valid flags and config
module two_wire_sensor_serial_master (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [6:0] reg_addr, [14:7] write_value, [15] sdio_in
    input  logic [1:0]  s_tuser,   // [1:0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [0] sclk_out, [1] sdio_drive_low, [9:2] read_value,
                                   // [10] busy_res, [15:11] zero
    output logic        m_tlast,   // done_res
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);
    import twsm_pkg::*;

    // configuration
    logic [7:0]  half_bit_reg;
    logic [7:0]  hold_reg;
    logic [7:0]  resync_low_reg;
    logic [15:0] resync_wait_reg;

    // tick state
    phase_t      phase_reg, phase_next;
    logic [3:0]  bit_index_reg, bit_index_next;
    logic [15:0] tick_count_reg, tick_count_next;
    logic [15:0] out_shift_reg, out_shift_next;
    logic [7:0]  in_shift_reg, in_shift_next;
    logic        is_read_reg, is_read_next;

    // output stage
    logic        out_valid_reg, skid_valid_reg;
    result_t     out_data_reg, skid_data_reg;
    result_t     result;

    logic        s_accept, m_take;
    logic [1:0]  op;
    logic [6:0]  reg_addr;
    logic [7:0]  write_value;
    logic        sdio_in;

    // state after a possible command start
    phase_t      ph_eff;
    logic [3:0]  bi_eff;
    logic [15:0] tc_eff;
    logic [15:0] os_eff;
    logic        ir_eff;

    logic [7:0]  half_eff, rlow_eff;
    logic [8:0]  period;
    logic [16:0] tick_inc;
    logic        bit_end, last_bit, low_end, wait_end, hold_end;

    assign op          = s_tuser;
    assign reg_addr    = s_tdata[6:0];
    assign write_value = s_tdata[14:7];
    assign sdio_in     = s_tdata[15];

    assign s_tready = ~skid_valid_reg;
    assign s_accept = s_tvalid & s_tready;
    assign m_take   = m_tvalid & m_tready;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_bit_reg    <= HALF_BIT_RESET;
            hold_reg        <= HOLD_RESET;
            resync_low_reg  <= RESYNC_LOW_RESET;
            resync_wait_reg <= RESYNC_WAIT_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_HALF_BIT:    half_bit_reg    <= cfg_wdata[7:0];
                CFG_HOLD:        hold_reg        <= cfg_wdata[7:0];
                CFG_RESYNC_LOW:  resync_low_reg  <= cfg_wdata[7:0];
                CFG_RESYNC_WAIT: resync_wait_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // zero half period or zero low time counts as one tick
    assign half_eff = (half_bit_reg == 8'd0) ? 8'd1 : half_bit_reg;
    assign rlow_eff = (resync_low_reg == 8'd0) ? 8'd1 : resync_low_reg;
    assign period   = {half_eff, 1'b0};

    // command start while idle takes effect on the same tick
    always_comb begin
        ph_eff = phase_reg;
        bi_eff = bit_index_reg;
        tc_eff = tick_count_reg;
        os_eff = out_shift_reg;
        ir_eff = is_read_reg;
        if (phase_reg == PH_IDLE && op != OP_TICK) begin
            tc_eff = 16'd0;
            case (op)
                OP_RESYNC: begin
                    ph_eff = PH_RSLOW;
                    ir_eff = 1'b0;
                end
                OP_READ: begin
                    ph_eff = PH_SEND;
                    ir_eff = 1'b1;
                    os_eff = {1'b0, reg_addr, 8'h00};
                    bi_eff = READ_LAST_BIT;
                end
                default: begin
                    ph_eff = PH_SEND;
                    ir_eff = 1'b0;
                    os_eff = {WRITE_FLAG | {1'b0, reg_addr}, write_value};
                    bi_eff = WRITE_LAST_BIT;
                end
            endcase
        end
    end

    // shared counter compares
    assign tick_inc = {1'b0, tc_eff} + 17'd1;
    assign bit_end  = tick_inc >= {8'd0, period};
    assign last_bit = bi_eff == 4'd0;
    assign hold_end = tick_inc >= {9'd0, hold_reg};
    assign low_end  = tick_inc >= {9'd0, rlow_eff};
    assign wait_end = tick_inc >= {1'b0, resync_wait_reg};

    // next state
    always_comb begin
        phase_next      = ph_eff;
        bit_index_next  = bi_eff;
        tick_count_next = tick_inc[15:0];
        out_shift_next  = os_eff;
        in_shift_next   = in_shift_reg;
        is_read_next    = ir_eff;
        case (ph_eff)
            PH_SEND: begin
                if (bit_end) begin
                    tick_count_next = 16'd0;
                    if (last_bit) begin
                        if (!ir_eff) begin
                            phase_next = PH_IDLE;
                        end else if (hold_reg != 8'd0) begin
                            phase_next = PH_HOLD;
                        end else begin
                            phase_next     = PH_RECV;
                            bit_index_next = READ_LAST_BIT;
                        end
                    end else begin
                        bit_index_next = bi_eff - 4'd1;
                        out_shift_next = {os_eff[14:0], 1'b0};
                    end
                end
            end
            PH_HOLD: begin
                if (hold_end) begin
                    phase_next      = PH_RECV;
                    bit_index_next  = READ_LAST_BIT;
                    tick_count_next = 16'd0;
                end
            end
            PH_RECV: begin
                // sample on the first high tick of the bit
                if (tc_eff == {8'd0, half_eff}) begin
                    in_shift_next = {in_shift_reg[6:0], sdio_in};
                end
                if (bit_end) begin
                    tick_count_next = 16'd0;
                    if (last_bit) begin
                        phase_next = PH_IDLE;
                    end else begin
                        bit_index_next = bi_eff - 4'd1;
                    end
                end
            end
            PH_RSLOW: begin
                if (low_end) begin
                    tick_count_next = 16'd0;
                    phase_next = (resync_wait_reg != 16'd0) ? PH_RSWAIT : PH_IDLE;
                end
            end
            PH_RSWAIT: begin
                if (wait_end) begin
                    tick_count_next = 16'd0;
                    phase_next      = PH_IDLE;
                end
            end
            default: begin
                tick_count_next = tc_eff;
            end
        endcase
    end

    // pin levels and status of this tick
    always_comb begin
        result            = '0;
        result.sclk       = 1'b1;
        result.read_value = in_shift_next;
        result.busy       = ph_eff != PH_IDLE;
        case (ph_eff)
            PH_SEND: begin
                result.sclk      = tc_eff >= {8'd0, half_eff};
                result.drive_low = ~os_eff[15];
                result.done      = bit_end & last_bit & ~ir_eff;
            end
            PH_HOLD: ;
            PH_RECV: begin
                result.sclk = tc_eff >= {8'd0, half_eff};
                result.done = bit_end & last_bit;
            end
            PH_RSLOW: begin
                result.sclk = 1'b0;
                result.done = low_end & (resync_wait_reg == 16'd0);
            end
            PH_RSWAIT: begin
                result.done = wait_end;
            end
            default: ;
        endcase
    end

    // tick state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            bit_index_reg  <= 4'd0;
            tick_count_reg <= 16'd0;
            out_shift_reg  <= 16'd0;
            in_shift_reg   <= 8'd0;
            is_read_reg    <= 1'b0;
        end else if (s_accept) begin
            phase_reg      <= phase_next;
            bit_index_reg  <= bit_index_next;
            tick_count_reg <= tick_count_next;
            out_shift_reg  <= out_shift_next;
            in_shift_reg   <= in_shift_next;
            is_read_reg    <= is_read_next;
        end
    end

    // output register with skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_take) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (s_accept) begin
            if (!out_valid_reg || m_take) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (m_take) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_take) begin
                out_data_reg <= skid_data_reg;
            end
        end else if (s_accept) begin
            if (!out_valid_reg || m_take) begin
                out_data_reg <= result;
            end else begin
                skid_data_reg <= result;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_data_reg.done;
    assign m_tdata  = {5'd0, out_data_reg.busy, out_data_reg.read_value,
                       out_data_reg.drive_low, out_data_reg.sclk};

    // checks
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without output entry");

    a_write_starts_send: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && phase_reg == PH_IDLE && op == OP_WRITE) |=> phase_reg == PH_SEND)
        else $error("write request did not enter send phase");

    a_recv_bit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_RECV |-> bit_index_reg <= READ_LAST_BIT)
        else $error("receive bit index out of range");

    a_done_is_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && result.done) |=> phase_reg == PH_IDLE)
        else $error("command done but phase not idle");

endmodule

[tb/twsm_checker.sv]
`timescale 1ns / 100ps
// checker for the two-wire sensor serial master: watches requests, config writes and results
// predicts every result from its own copy of the line state; depends on twsm_pkg
module twsm_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // [6:0] reg_addr, [14:7] write_value, [15] sdio_in
    input  logic [1:0]  s_tuser,   // [1:0] op
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // [0] sclk_out, [1] sdio_drive_low, [9:2] read_value,
                                   // [10] busy_res, [15:11] zero
    input  logic        m_tlast,   // done_res
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    output int          outstanding,
    output int          failures
);
    import twsm_pkg::*;

    // shadow copy of the configuration registers
    logic [7:0]  half_bit;
    logic [7:0]  hold_len;
    logic [7:0]  resync_low;
    logic [15:0] resync_wait;

    // shadow copy of the master state
    phase_t      phase;
    logic [3:0]  bit_idx;
    logic [15:0] ticks;
    logic [15:0] out_sr;
    logic [7:0]  in_sr;
    logic        reading;

    result_t line_forecast[$];
    int      mismatches;

    task automatic begin_receive();
        phase   = PH_RECV;
        bit_idx = READ_LAST_BIT;
        ticks   = '0;
    endtask

    // one base tick of the master: updates the shadow state, returns the line levels
    task automatic step_serial_master(input logic [1:0] op, input logic [6:0] addr,
                                      input logic [7:0] wval, input logic sdio,
                                      output result_t r);
        int half;
        int rlow;
        int span;
        half = (half_bit == 8'd0) ? 1 : int'(half_bit);
        rlow = (resync_low == 8'd0) ? 1 : int'(resync_low);
        span = 2 * half;
        r = '0;
        r.sclk = 1'b1;

        // a command is only taken while idle, and starts on this very tick
        if (phase == PH_IDLE && op != OP_TICK) begin
            ticks = '0;
            case (op)
                OP_RESYNC: begin
                    phase   = PH_RSLOW;
                    reading = 1'b0;
                end
                OP_READ: begin
                    phase   = PH_SEND;
                    reading = 1'b1;
                    out_sr  = {1'b0, addr, 8'h00};
                    bit_idx = READ_LAST_BIT;
                end
                default: begin
                    phase   = PH_SEND;
                    reading = 1'b0;
                    out_sr  = {WRITE_FLAG | {1'b0, addr}, wval};
                    bit_idx = WRITE_LAST_BIT;
                end
            endcase
        end

        r.busy = (phase != PH_IDLE);

        case (phase)
            PH_SEND: begin
                r.sclk      = (int'(ticks) >= half);
                r.drive_low = ~out_sr[15];
                ticks = ticks + 16'd1;
                if (int'(ticks) >= span) begin
                    ticks = '0;
                    if (bit_idx == 4'd0) begin
                        if (!reading) begin
                            phase  = PH_IDLE;
                            r.done = 1'b1;
                        end else if (hold_len != 8'd0) begin
                            phase = PH_HOLD;
                        end else begin
                            begin_receive();
                        end
                    end else begin
                        bit_idx = bit_idx - 4'd1;
                        out_sr  = out_sr << 1;
                    end
                end
            end
            PH_HOLD: begin
                ticks = ticks + 16'd1;
                if (ticks >= {8'd0, hold_len}) begin_receive();
            end
            PH_RECV: begin
                r.sclk = (int'(ticks) >= half);
                // sample on the first high tick of the bit
                if (int'(ticks) == half) in_sr = {in_sr[6:0], sdio};
                ticks = ticks + 16'd1;
                if (int'(ticks) >= span) begin
                    ticks = '0;
                    if (bit_idx == 4'd0) begin
                        phase  = PH_IDLE;
                        r.done = 1'b1;
                    end else begin
                        bit_idx = bit_idx - 4'd1;
                    end
                end
            end
            PH_RSLOW: begin
                r.sclk = 1'b0;
                ticks = ticks + 16'd1;
                if (int'(ticks) >= rlow) begin
                    ticks = '0;
                    if (resync_wait != 16'd0) begin
                        phase = PH_RSWAIT;
                    end else begin
                        phase  = PH_IDLE;
                        r.done = 1'b1;
                    end
                end
            end
            PH_RSWAIT: begin
                ticks = ticks + 16'd1;
                if (ticks >= resync_wait) begin
                    ticks  = '0;
                    phase  = PH_IDLE;
                    r.done = 1'b1;
                end
            end
            default: phase = PH_IDLE;
        endcase

        r.read_value = in_sr;
    endtask

    // watch config writes, requests and results on every edge
    always @(posedge aclk) begin
        result_t want;
        result_t got;
        if (!aresetn) begin
            half_bit    = HALF_BIT_RESET;
            hold_len    = HOLD_RESET;
            resync_low  = RESYNC_LOW_RESET;
            resync_wait = RESYNC_WAIT_RESET;
            phase       = PH_IDLE;
            bit_idx     = '0;
            ticks       = '0;
            out_sr      = '0;
            in_sr       = '0;
            reading     = 1'b0;
            mismatches  = 0;
            line_forecast.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_HALF_BIT:   half_bit    = cfg_wdata[7:0];
                    CFG_HOLD:       hold_len    = cfg_wdata[7:0];
                    CFG_RESYNC_LOW: resync_low  = cfg_wdata[7:0];
                    default:        resync_wait = cfg_wdata;
                endcase
            end

            if (s_tvalid && s_tready) begin
                step_serial_master(s_tuser, s_tdata[6:0], s_tdata[14:7], s_tdata[15], want);
                line_forecast.push_back(want);
            end

            if (m_tvalid && m_tready) begin
                got.sclk       = m_tdata[0];
                got.drive_low  = m_tdata[1];
                got.read_value = m_tdata[9:2];
                got.busy       = m_tdata[10];
                got.done       = m_tlast;
                if (line_forecast.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with no request waiting: tdata %h tlast %b",
                                 $realtime, m_tdata, m_tlast);
                end else begin
                    want = line_forecast.pop_front();
                    if (got !== want || m_tdata[15:11] !== 5'd0) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: mismatch sclk %b/%b drive %b/%b read %h/%h",
                                     $realtime, want.sclk, got.sclk,
                                     want.drive_low, got.drive_low,
                                     want.read_value, got.read_value);
                            $display("    busy %b/%b done %b/%b pad %b (expected/actual)",
                                     want.busy, got.busy, want.done, got.done,
                                     m_tdata[15:11]);
                        end
                    end
                end
            end
        end
        outstanding <= line_forecast.size();
        failures    <= mismatches;
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// top of the testbench for two_wire_sensor_serial_master: clock, reset, requests, config
// writes and result-side stalls; checking sits in twsm_checker; depends on twsm_pkg
module tb;
    import twsm_pkg::*;

    localparam int CYCLE_LIMIT  = 4_000_000;
    localparam int RANDOM_ITEMS = 700;
    localparam int PHASE_ITEMS  = 140;
    localparam int CALM_ITEMS   = 300;

    // data line levels for runs of plain ticks
    localparam int SDIO_LOW    = 0;
    localparam int SDIO_HIGH   = 1;
    localparam int SDIO_RANDOM = 2;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = OP_TICK;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = CFG_HALF_BIT;
    logic [15:0] cfg_wdata = '0;

    int outstanding;
    int failures;
    int cycles     = 0;
    int stall_left = 0;
    bit idling_on  = 1'b1;

    always #5 aclk = ~aclk;

    two_wire_sensor_serial_master dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    twsm_checker chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .outstanding (outstanding),
        .failures    (failures)
    );

    // result side: random stall bursts while idling is on
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (aresetn && idling_on && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(1, 10) - 1;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= aresetn;
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // one request, with an optional gap in front of it
    task automatic send_req(input logic [1:0] op, input logic [6:0] addr,
                            input logic [7:0] wval, input logic sdio);
        int gap;
        if (idling_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 10);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {sdio, wval, addr};
        do @(posedge aclk); while (!s_tready);
    endtask

    // plain ticks with the data line held or random
    task automatic run_ticks(input int n, input int level);
        logic sdio;
        for (int i = 0; i < n; i++) begin
            sdio = (level == SDIO_RANDOM) ? 1'($urandom) : (level == SDIO_HIGH);
            send_req(OP_TICK, 7'($urandom), 8'($urandom), sdio);
        end
    endtask

    // hold off until every result is back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    // all four registers, junk in the unused upper byte of the narrow ones
    task automatic set_config(input logic [7:0] half, input logic [7:0] hold,
                              input logic [7:0] rlow, input logic [15:0] rwait);
        drain();
        write_reg(CFG_HALF_BIT, {8'($urandom), half});
        write_reg(CFG_HOLD, {8'($urandom), hold});
        write_reg(CFG_RESYNC_LOW, {8'($urandom), rlow});
        write_reg(CFG_RESYNC_WAIT, rwait);
        cfg_we <= 1'b0;
    endtask

    initial begin
        int          sent;
        logic [1:0]  op;
        logic [7:0]  half;
        logic [7:0]  hold;
        logic [7:0]  rlow;
        logic [15:0] rwait;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: read with the line high, then the start of a resync
        send_req(OP_READ, 7'h7F, 8'hA5, 1'b1);
        run_ticks(170, SDIO_HIGH);
        send_req(OP_RESYNC, 7'h00, 8'h00, 1'b0);
        run_ticks(30, SDIO_RANDOM);

        // fastest timing, zero hold, zero resync low and zero resync wait
        set_config(8'd1, 8'd0, 8'd0, 16'd0);
        // the pending resync wait ends on the first tick
        run_ticks(2, SDIO_RANDOM);
        send_req(OP_READ, 7'h00, 8'h00, 1'b0);
        run_ticks(40, SDIO_LOW);
        send_req(OP_WRITE, 7'h7F, 8'hFF, 1'b1);
        run_ticks(40, SDIO_RANDOM);
        send_req(OP_WRITE, 7'h00, 8'h00, 1'b0);
        run_ticks(40, SDIO_RANDOM);
        send_req(OP_RESYNC, 7'h7F, 8'hFF, 1'b1);
        run_ticks(3, SDIO_RANDOM);
        // a read, then a write and a resync that come while it is busy and are dropped
        send_req(OP_READ, 7'h55, 8'h3C, 1'b1);
        send_req(OP_WRITE, 7'h2A, 8'hC3, 1'b0);
        send_req(OP_RESYNC, 7'h7F, 8'hFF, 1'b1);
        run_ticks(40, SDIO_RANDOM);
        send_req(OP_TICK, 7'h7F, 8'hFF, 1'b1);

        // zero half period, short hold and resync phases
        set_config(8'd0, 8'd2, 8'd3, 16'd4);
        send_req(OP_READ, 7'h2A, 8'h00, 1'b1);
        run_ticks(45, SDIO_RANDOM);
        send_req(OP_WRITE, 7'h15, 8'h5A, 1'b0);
        run_ticks(40, SDIO_RANDOM);
        send_req(OP_RESYNC, 7'h00, 8'h00, 1'b0);
        run_ticks(12, SDIO_RANDOM);

        // slowest settings: the first bit and part of the second bit of a write
        set_config(8'd255, 8'd255, 8'd255, 16'hFFFF);
        send_req(OP_WRITE, 7'($urandom), 8'($urandom), 1'b0);
        run_ticks(600, SDIO_RANDOM);

        // random phases: new timing each phase, sparse commands among ticks
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       half = 8'd0;
                1, 2, 3, 4, 5: half = 8'($urandom_range(1, 2));
                6, 7, 8: half = 8'($urandom_range(3, 6));
                default: half = 8'($urandom_range(1, 255));
            endcase
            hold  = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
            rlow  = 8'($urandom_range(0, 4));
            rwait = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 30));
            set_config(half, hold, rlow, rwait);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (sent >= RANDOM_ITEMS - CALM_ITEMS) idling_on <= 1'b0;
                op = ($urandom_range(0, 11) == 0) ? 2'($urandom_range(1, 3)) : OP_TICK;
                send_req(op, 7'($urandom), 8'($urandom), 1'($urandom));
                sent++;
            end
        end

        drain();
        repeat (8) @(posedge aclk);
        if (failures == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
